FILE: src/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared widths, operation and status codes, and the cell control types
// of the indexed list.
// ----------------------------------------------------------------------------
package ilir_pkg;

  // item field widths
  localparam int unsigned OP_BITS     = 3;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned LENGTH_BITS = 7;
  localparam int unsigned STATUS_BITS = 2;

  // default geometry
  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned WORD_BITS_DEF = 32;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_READ   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd2;

  // command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e           cmd;
    logic [POS_BITS-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: src/ilir_in_if.sv
// ----------------------------------------------------------------------------
// ilir_in_if
// Request channel of the indexed list: operation, position and value.
// ----------------------------------------------------------------------------
interface ilir_in_if;
  logic                             valid;
  logic                             ready;
  logic [ilir_pkg::OP_BITS-1:0]     op;
  logic [ilir_pkg::POS_BITS-1:0]    position;
  logic [ilir_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

FILE: src/ilir_out_if.sv
// ----------------------------------------------------------------------------
// ilir_out_if
// Response channel of the indexed list: data word, length and status.
// ----------------------------------------------------------------------------
interface ilir_out_if;
  logic                              valid;
  logic                              ready;
  logic [ilir_pkg::DATA_BITS-1:0]    data;
  logic [ilir_pkg::LENGTH_BITS-1:0]  length;
  logic [ilir_pkg::STATUS_BITS-1:0]  status;

  modport source (output valid, output data, output length, output status, input ready);
  modport sink   (input valid, input data, input length, input status, output ready);
endinterface

FILE: src/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell
// One element slot of the list. Holds a word, loads the new value, takes
// its lower or upper neighbor's word on a shift, and offers its word when
// addressed.
// ----------------------------------------------------------------------------
module ilir_cell #(
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF,
  parameter int unsigned INDEX     = 0
) (
  input  logic                 clk_i,
  input  ilir_pkg::cell_ctrl_t ctrl_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] tap_o
);
  import ilir_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 hit;
  logic                 above;

  assign hit   = 32'(ctrl_i.pos) == 32'(INDEX);
  assign above = 32'(INDEX) > 32'(ctrl_i.pos);

  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
        word_d = word_q;
      end
      CMD_WRITE: begin
        if (hit) word_d = value_i;
      end
      CMD_SHIFT_UP: begin
        if (hit) begin
          word_d = value_i;
        end else if (above) begin
          word_d = left_i;
        end
      end
      CMD_SHIFT_DOWN: begin
        if (hit || above) word_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = hit ? word_q : '0;

endmodule

FILE: src/indexed_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered list of up to DEPTH words addressed by position, built as a row
// of cells that shift together, from the position up, on insert and remove.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled and answers it in the next
// cycle: an insert or remove moves every later element by one slot at once
// across the row of cells, and the read of the addressed word is an OR over
// the cell taps in the same cycle as acceptance. A new item is taken whenever
// the output register is empty or being emptied. No clearing pass after
// reset: the list length starts at zero and only held positions are read.
module indexed_list_insert_remove_top #(
  parameter int unsigned DEPTH     = ilir_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilir_in_if.sink    in_i,
  ilir_out_if.source out_o
);
  import ilir_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [FW-1:0]          fill_q, fill_d;
  logic                   out_valid_q;
  logic [DATA_BITS-1:0]   data_q, data_d;
  logic [LENGTH_BITS-1:0] length_q;
  logic [STATUS_BITS-1:0] status_q, status_d;

  cell_ctrl_t             ctrl;
  logic [WORD_BITS-1:0]   value_word;
  logic [WORD_BITS-1:0]   words [DEPTH];
  logic [WORD_BITS-1:0]   taps  [DEPTH];
  logic [WORD_BITS-1:0]   sel_word;
  logic                   in_fire;
  logic                   in_bounds;
  logic [31:0]            pos_w;
  logic [31:0]            fill_w;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign value_word = WORD_BITS'(in_i.value);
  assign pos_w      = 32'(in_i.position);
  assign fill_w     = 32'(fill_q);
  assign in_bounds  = pos_w < fill_w;

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end

    ilir_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_word),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[g]),
      .tap_o   (taps[g])
    );
  end

  // at most one cell taps, so an OR selects the addressed word
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_word = sel_word | taps[i];
    end
  end

  always_comb begin
    ctrl.cmd = CMD_HOLD;
    ctrl.pos = in_i.position;
    fill_d   = fill_q;
    data_d   = '0;
    status_d = ST_OK;
    if (in_fire) begin
      unique case (in_i.op)
        OP_READ: begin
          if (in_bounds) begin
            data_d = DATA_BITS'(sel_word);
          end else begin
            status_d = ST_BOUNDS;
          end
        end
        OP_WRITE: begin
          if (in_bounds) begin
            data_d   = DATA_BITS'(sel_word);
            ctrl.cmd = CMD_WRITE;
          end else begin
            status_d = ST_BOUNDS;
          end
        end
        OP_INSERT: begin
          if (pos_w > fill_w) begin
            status_d = ST_BOUNDS;
          end else if (fill_w == 32'(DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            ctrl.cmd = CMD_SHIFT_UP;
            fill_d   = FW'(fill_q + 1'b1);
            data_d   = DATA_BITS'(value_word);
          end
        end
        OP_REMOVE: begin
          if (in_bounds) begin
            data_d   = DATA_BITS'(sel_word);
            ctrl.cmd = CMD_SHIFT_DOWN;
            fill_d   = FW'(fill_q - 1'b1);
          end else begin
            status_d = ST_BOUNDS;
          end
        end
        OP_CLEAR: begin
          fill_d = '0;
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= in_fire || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q   <= data_d;
      length_q <= LENGTH_BITS'(fill_d);
      status_q <= status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = data_q;
  assign out_o.length = length_q;
  assign out_o.status = status_q;

`ifndef SYNTHESIS
  a_fill_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(DEPTH))
    else $error("list length beyond depth");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item left no result");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> 32'(fill_q) == 32'(DEPTH))
    else $error("full status while list not full");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ctrl.cmd == CMD_SHIFT_UP |=> fill_q == FW'($past(fill_q) + 1'b1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ctrl.cmd == CMD_SHIFT_DOWN |=> fill_q == FW'($past(fill_q) - 1'b1))
    else $error("remove did not shrink the list");
`endif

endmodule

FILE: dv/ilir_list_checker.sv
// ----------------------------------------------------------------------------
// ilir_list_checker
// Watches the request and response channels of the indexed list, keeps its
// own copy of the list, and compares every response with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ilir_list_checker #(
  parameter int unsigned DEPTH     = ilir_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilir_in_if          req_i,
  ilir_out_if         resp_i,
  output int unsigned held_count_o,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilir_pkg::*;

  typedef struct packed {
    logic [DATA_BITS-1:0]   data;
    logic [LENGTH_BITS-1:0] length;
    logic [STATUS_BITS-1:0] status;
  } list_result_t;

  localparam logic [VALUE_BITS-1:0] WORD_MASK = (WORD_BITS >= VALUE_BITS) ?
    {VALUE_BITS{1'b1}} : VALUE_BITS'((64'd1 << WORD_BITS) - 64'd1);

  logic [DATA_BITS-1:0] list_words [DEPTH];
  int unsigned          held       = 0;
  int unsigned          fail_count = 0;
  int unsigned          pending    = 0;
  list_result_t         expected_results [$];
  list_result_t         want;

  assign held_count_o = held;
  assign pending_o    = pending;
  assign fail_count_o = fail_count;

  // applies one item to the shadow list and returns the response it earns
  function automatic list_result_t apply_list_op(input logic [OP_BITS-1:0]    op,
                                                 input logic [POS_BITS-1:0]   pos,
                                                 input logic [VALUE_BITS-1:0] value);
    list_result_t res;
    int unsigned  p;
    int unsigned  i;
    res.data   = '0;
    res.status = ST_OK;
    p = pos;
    case (op)
      OP_READ: begin
        if (p >= held) res.status = ST_BOUNDS;
        else res.data = list_words[p];
      end
      OP_WRITE: begin
        if (p >= held) begin
          res.status = ST_BOUNDS;
        end else begin
          res.data      = list_words[p];
          list_words[p] = value & WORD_MASK;
        end
      end
      OP_INSERT: begin
        // bounds first, full second; insert at the length appends
        if (p > held) begin
          res.status = ST_BOUNDS;
        end else if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = held; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = value & WORD_MASK;
          held++;
          res.data = value & WORD_MASK;
        end
      end
      OP_REMOVE: begin
        if (p >= held) begin
          res.status = ST_BOUNDS;
        end else begin
          res.data = list_words[p];
          for (i = p; i + 1 < held; i++) list_words[i] = list_words[i+1];
          held--;
        end
      end
      OP_CLEAR: held = 0;
      default: ;
    endcase
    res.length = LENGTH_BITS'(held);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      // response first: it answers an older item, never the request accepted now
      if (resp_i.valid && resp_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("response with no item pending: data %h length %0d status %0d",
                 resp_i.data, resp_i.length, resp_i.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (resp_i.data !== want.data) begin
            $error("data: expected %h, actual %h", want.data, resp_i.data);
            fail_count++;
          end
          if (resp_i.length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, resp_i.length);
            fail_count++;
          end
          if (resp_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, resp_i.status);
            fail_count++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_results.push_back(apply_list_op(req_i.op, req_i.position, req_i.value));
      pending = expected_results.size();
    end
  end

endmodule

FILE: dv/indexed_list_insert_remove_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top_tb
// Drives the indexed list with directed corner items, a fill to capacity and
// phased random traffic under random bursts and response stalls; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ilir_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned MAX_POS      = (1 << POS_BITS) - 1;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
  typedef enum {PH_GROW, PH_SHRINK, PH_MIX} traffic_phase_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned held_count;
  int unsigned results_pending;
  int unsigned fail_count;
  int unsigned burst_left = 0;

  ilir_in_if  req_ch ();
  ilir_out_if resp_ch ();

  indexed_list_insert_remove_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (resp_ch)
  );

  ilir_list_checker list_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .resp_i       (resp_ch),
    .held_count_o (held_count),
    .pending_o    (results_pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("indexed_list_insert_remove_top_tb: FAIL");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [OP_BITS-1:0]    op,
                           input logic [POS_BITS-1:0]   pos,
                           input logic [VALUE_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
                                                 $urandom_range(1, 12);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= value;
    do @(posedge clk_i); while (!req_ch.ready);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
  endtask

  // response side stalls on its own changing pattern
  initial begin : resp_stall
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned cyc;
    resp_ch.ready = 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    cyc       = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cyc++;
      case (mode)
        STALL_NONE:  resp_ch.ready <= 1'b1;
        STALL_LIGHT: resp_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: resp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     resp_ch.ready <= (cyc % 6 == 0);
      endcase
    end
  end

  initial begin : stimulus
    traffic_phase_e          phase;
    int unsigned             phase_left;
    int unsigned             items_sent;
    int unsigned             roll;
    int unsigned             top_pos;
    logic [OP_BITS-1:0]      op;
    logic [POS_BITS-1:0]     pos;
    logic [VALUE_BITS-1:0]   value;

    req_ch.valid    = 1'b0;
    req_ch.op       = OP_READ;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: everything but insert at zero is out of bounds
    send_item(OP_READ,   '0, '0);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_WRITE,  '0, 32'h1111_1111);
    send_item(OP_INSERT, 6'd1, 32'h2222_2222);
    // append, prepend and a middle insert
    send_item(OP_INSERT, 6'd0, '0);
    send_item(OP_INSERT, 6'd1, '1);
    send_item(OP_INSERT, 6'd0, 32'hA5A5_A5A5);
    send_item(OP_INSERT, 6'd1, 32'h5A5A_5A5A);
    send_item(OP_READ,   6'd0, '0);
    send_item(OP_READ,   6'd1, '0);
    send_item(OP_READ,   6'd2, '0);
    send_item(OP_READ,   6'd3, '1);
    send_item(OP_READ,   6'd4, '0);
    send_item(OP_READ,   6'd63, '0);
    send_item(OP_WRITE,  6'd2, 32'h1234_5678);
    send_item(OP_WRITE,  6'd4, 32'hDEAD_BEEF);
    send_item(OP_REMOVE, 6'd1, '0);
    send_item(OP_REMOVE, 6'd2, '0);
    send_item(OP_REMOVE, 6'd5, '0);
    // unused op codes leave the list alone
    send_item(OP_BITS'(5), 6'd63, '1);
    send_item(OP_BITS'(6), 6'd0, '1);
    send_item(OP_BITS'(7), 6'd1, 32'h0F0F_0F0F);
    send_item(OP_CLEAR,  6'd17, '1);
    send_item(OP_READ,   6'd0, '0);
    send_item(OP_CLEAR,  '0, '0);
    wait_drained();

    // fill to capacity, then poke at the full list
    while (held_count < DEPTH_DEF) begin
      top_pos = (held_count > MAX_POS) ? MAX_POS : held_count;
      send_item(OP_INSERT, POS_BITS'($urandom_range(0, top_pos)), $urandom());
    end
    send_item(OP_INSERT, 6'd0, $urandom());
    send_item(OP_INSERT, 6'd63, $urandom());
    send_item(OP_READ,   6'd63, '0);
    send_item(OP_WRITE,  6'd63, $urandom());
    send_item(OP_REMOVE, 6'd0, '0);
    send_item(OP_INSERT, 6'd63, $urandom());
    send_item(OP_INSERT, 6'd5, $urandom());
    send_item(OP_REMOVE, 6'd63, '0);
    wait_drained();

    phase      = PH_MIX;
    phase_left = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = traffic_phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) wait_drained();
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      case (phase)
        PH_GROW:
          op = (roll < 55) ? OP_INSERT : (roll < 70) ? OP_READ : (roll < 85) ? OP_WRITE :
               (roll < 97) ? OP_REMOVE : (roll < 98) ? OP_CLEAR : OP_BITS'($urandom_range(5, 7));
        PH_SHRINK:
          op = (roll < 55) ? OP_REMOVE : (roll < 67) ? OP_INSERT : (roll < 82) ? OP_READ :
               (roll < 97) ? OP_WRITE : (roll < 98) ? OP_CLEAR : OP_BITS'($urandom_range(5, 7));
        default:
          op = (roll < 25) ? OP_INSERT : (roll < 50) ? OP_REMOVE : (roll < 70) ? OP_READ :
               (roll < 90) ? OP_WRITE : (roll < 94) ? OP_CLEAR : OP_BITS'($urandom_range(5, 7));
      endcase

      // mostly held positions, with edges and raw noise mixed in
      top_pos = (op == OP_INSERT) ? held_count : ((held_count == 0) ? 0 : held_count - 1);
      if (top_pos > MAX_POS) top_pos = MAX_POS;
      roll = $urandom_range(0, 9);
      if (roll == 0)      pos = POS_BITS'($urandom());
      else if (roll == 1) pos = POS_BITS'(top_pos);
      else if (roll == 2) pos = POS_BITS'((held_count > MAX_POS) ? MAX_POS : held_count);
      else if (roll == 3) pos = '0;
      else                pos = POS_BITS'($urandom_range(0, top_pos));

      roll = $urandom_range(0, 15);
      value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();

      send_item(op, pos, value);
      items_sent++;
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("indexed_list_insert_remove_top_tb: PASS");
    end else begin
      $display("indexed_list_insert_remove_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ilir_pkg.sv
src/ilir_in_if.sv
src/ilir_out_if.sv
src/ilir_cell.sv
src/indexed_list_insert_remove_top.sv
dv/ilir_list_checker.sv
dv/indexed_list_insert_remove_top_tb.sv
